// ----- design/cer_pkg.sv -----
// Shared types and constants for the connected edge removal block.
// No dependencies; every other design file imports this package.
package cer_pkg;

   localparam int unsigned MAX_NODES_DEF = 32;   // built matrix size
   localparam int unsigned NODE_W        = 6;    // endpoint and node count field width
   localparam int unsigned COUNT_W       = 10;   // edge count field width
   localparam int unsigned STATUS_W      = 2;
   localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 6'd32;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_RANGE      = 2'd1,
      STATUS_DISCONNECT = 2'd2,
      STATUS_NO_EDGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_CHECK,
      ST_WALK,
      ST_WR_A,
      ST_WR_B,
      ST_RESP
   } state_type;

endpackage

// ----- design/cer_req_if.sv -----
// Request channel of the connected edge removal block: valid/ready plus payload.
// Depends on cer_pkg for field widths.
interface cer_req_if import cer_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [NODE_W-1:0] from_node;
   logic [NODE_W-1:0] to_node;

   modport source (output valid, cmd, from_node, to_node, input ready);
   modport sink   (input valid, cmd, from_node, to_node, output ready);
endinterface

// ----- design/cer_rsp_if.sv -----
// Response channel of the connected edge removal block: valid/ready plus payload.
// Depends on cer_pkg for field widths.
interface cer_rsp_if import cer_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  edge_count;

   modport source (output valid, status, edge_count, input ready);
   modport sink   (input valid, status, edge_count, output ready);
endinterface

// ----- design/cer_adj_mem.sv -----
// Adjacency matrix storage: one row per node, one write and one read port.
// Per-row valid bits make unwritten rows read as zero. Depends on cer_pkg.
module cer_adj_mem import cer_pkg::*; #(
   parameter int unsigned MAX_NODES = MAX_NODES_DEF,
   localparam int unsigned IDX_W    = $clog2(MAX_NODES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [MAX_NODES-1:0] rd_row,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [MAX_NODES-1:0] wr_row
);

   logic [MAX_NODES-1:0] mem_array [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff;
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
         rd_hit_ff  <= row_valid_ff[rd_addr];
      end
   end

   // Rows never written since reset read as empty.
   assign rd_row = rd_hit_ff ? rd_data_ff : '0;

endmodule

// ----- design/connected_edge_removal.sv -----
// Connected edge removal: undirected adjacency matrix with connectivity-guarded removal.
// An out-of-range request is answered without touching the matrix; otherwise both endpoint
// rows are read, and a remove of a present edge then walks the graph from node 1, reading one row
// per node reached; a refused removal skips both writes.
// One request in flight at a time; the next is taken once the response register is loaded.
// Reset (synchronous, active high) empties the matrix at once through per-row valid bits,
// zeroes the edge count and sets node_count to 32; no clearing pass is needed.
module connected_edge_removal import cer_pkg::*; #(
   parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   cer_req_if.sink           req,
   cer_rsp_if.source         rsp,
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(MAX_NODES);
   localparam int unsigned CMP_W = NODE_W + 1;   // room for MAX_NODES itself
   localparam logic [MAX_NODES-1:0] ONE_ROW = {{(MAX_NODES-1){1'b0}}, 1'b1};

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    node_count_ff;
   logic [COUNT_W-1:0]   edge_total_ff, edge_total_in;
   logic                 cmd_ff, cmd_in;
   logic [IDX_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [MAX_NODES-1:0] row_a_ff, row_a_in, row_b_ff, row_b_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] pending_ff, pending_in;
   logic                 inflight_ff, inflight_in;
   logic [IDX_W-1:0]     walk_node_ff, walk_node_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Memory port
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   logic [MAX_NODES-1:0] mem_rd_row;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [MAX_NODES-1:0] mem_wr_row;

   cer_adj_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_row  (mem_rd_row),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_row  (mem_wr_row)
   );

   // ---------------------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------------------
   logic [CMP_W-1:0]     node_count_ext;
   logic [CMP_W-1:0]     n_eff;
   logic [MAX_NODES-1:0] lim_mask;
   logic                 req_accept;
   logic                 in_range;

   // A node count above the built size acts as the built size.
   assign node_count_ext = {1'b0, node_count_ff};
   assign n_eff = (node_count_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : node_count_ext;

   // Nodes taking part in the walk: those below the effective count.
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         lim_mask[i] = (CMP_W'(i) < n_eff);
      end
   end

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;

   // Endpoints are 1-based; zero or anything above the effective count is refused.
   assign in_range = (req.from_node != '0) && (req.to_node != '0) &&
                     ({1'b0, req.from_node} <= n_eff) && ({1'b0, req.to_node} <= n_eff);

   // ---------------------------------------------------------------------------------
   // Edge test and walk datapath
   // ---------------------------------------------------------------------------------
   logic [MAX_NODES-1:0] bit_a, bit_b;
   logic                 has_edge;
   logic [MAX_NODES-1:0] walk_excl;
   logic [MAX_NODES-1:0] walk_new;
   logic                 pick_have;
   logic [IDX_W-1:0]     pick_idx;
   logic [MAX_NODES-1:0] pick_bit;
   logic                 walk_done;
   logic                 connected;
   logic                 rsp_free;

   assign bit_a    = ONE_ROW << a_ff;
   assign bit_b    = ONE_ROW << b_ff;
   assign has_edge = row_a_ff[b_ff];

   // The walk sees the graph with the candidate edge taken out, so the matrix
   // is only written once the removal is known to keep the graph connected.
   assign walk_excl = ((walk_node_ff == a_ff) ? bit_b : '0) |
                      ((walk_node_ff == b_ff) ? bit_a : '0);
   assign walk_new  = inflight_ff ? (mem_rd_row & lim_mask & ~visited_ff & ~walk_excl) : '0;

   // Expand the lowest pending node next; visit order does not change the reach.
   always_comb begin
      pick_idx = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
   end

   assign pick_have = |pending_ff;
   assign pick_bit  = ONE_ROW << pick_idx;
   assign walk_done = !pick_have && !inflight_ff;
   assign connected = &(visited_ff | ~lim_mask);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // ---------------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = in_range ? ST_RD_A : ST_RESP;
            end
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (cmd_ff == CMD_ADD) begin
               state_in = has_edge ? ST_RESP : ST_WR_A;
            end else begin
               state_in = has_edge ? ST_WALK : ST_RESP;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = connected ? ST_WR_A : ST_RESP;
            end
         end
         ST_WR_A:  state_in = ST_WR_B;
         ST_WR_B:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Datapath control and register next values
   // ---------------------------------------------------------------------------------
   always_comb begin
      // hold by default
      cmd_in        = cmd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      row_a_in      = row_a_ff;
      row_b_in      = row_b_ff;
      visited_in    = visited_ff;
      pending_in    = pending_ff;
      inflight_in   = 1'b0;
      walk_node_in  = walk_node_ff;
      status_in     = status_ff;
      edge_total_in = edge_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = a_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = a_ff;
      mem_wr_row    = row_a_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req.cmd;
               a_in      = IDX_W'(req.from_node - NODE_W'(1));
               b_in      = IDX_W'(req.to_node - NODE_W'(1));
               status_in = in_range ? STATUS_DONE : STATUS_RANGE;
            end
         end
         ST_RD_A: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = a_ff;
         end
         ST_RD_B: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = b_ff;
            row_a_in    = mem_rd_row;
         end
         ST_CHECK: begin
            row_b_in = mem_rd_row;
            if (cmd_ff == CMD_REMOVE) begin
               if (!has_edge) begin
                  status_in = STATUS_NO_EDGE;
               end else begin
                  // seed the walk at node 1
                  visited_in = ONE_ROW;
                  pending_in = ONE_ROW;
               end
            end
         end
         ST_WALK: begin
            // merge the row that came back, issue the next pending row
            visited_in = visited_ff | walk_new;
            pending_in = (pending_ff & ~(pick_have ? pick_bit : '0)) | walk_new;
            mem_rd_en   = pick_have;
            mem_rd_addr = pick_idx;
            inflight_in = pick_have;
            if (pick_have) begin
               walk_node_in = pick_idx;
            end
            if (walk_done && !connected) begin
               status_in = STATUS_DISCONNECT;
            end
         end
         ST_WR_A: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = a_ff;
            mem_wr_row  = (cmd_ff == CMD_ADD) ? (row_a_ff | bit_b) : (row_a_ff & ~bit_b);
         end
         ST_WR_B: begin
            // on a self loop this rewrites the same row with the same bit
            mem_wr_en     = 1'b1;
            mem_wr_addr   = b_ff;
            mem_wr_row    = (cmd_ff == CMD_ADD) ? (row_b_ff | bit_a) : (row_b_ff & ~bit_a);
            edge_total_in = (cmd_ff == CMD_ADD) ? (edge_total_ff + COUNT_W'(1))
                                                : (edge_total_ff - COUNT_W'(1));
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = edge_total_ff;
            end
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         edge_total_ff <= '0;
         visited_ff    <= '0;
         pending_ff    <= '0;
         inflight_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         visited_ff    <= visited_in;
         pending_ff    <= pending_in;
         inflight_ff   <= inflight_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      row_a_ff      <= row_a_in;
      row_b_ff      <= row_b_in;
      walk_node_ff  <= walk_node_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.edge_count = rsp_count_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   // The walk only reads; the matrix changes in the two write states alone.
   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !mem_wr_en)
      else $error("matrix written during connectivity walk");

   // The edge count moves only when the second row of an edge is written.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WR_B) |=> $stable(edge_total_ff))
      else $error("edge count changed outside a committed write");

   // The start node stays reached throughout a walk.
   a_walk_seed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> visited_ff[0])
      else $error("walk lost its start node");

   // A new response is loaded only from the response state.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("response raised outside the response state");

endmodule

// ----- test/tb_connected_edge_removal.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for connected_edge_removal: directed table, then random traffic.
// Depends on cer_pkg, cer_req_if, cer_rsp_if and the connected_edge_removal design files.
module tb_connected_edge_removal;
   import cer_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned SEGMENTS    = 9;
   localparam int unsigned ROWS        = 26;

   // One expected response: status plus edge count after the request.
   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] edge_count;
   } graph_result_type;

   // One line of the directed table: either a node_count write or a request.
   // Where known is set, the response is typed in; otherwise the predictor decides.
   typedef struct packed {
      bit                 is_cfg;
      logic [NODE_W-1:0]  cfg_value;
      logic               cmd;
      logic [NODE_W-1:0]  from_node;
      logic [NODE_W-1:0]  to_node;
      bit                 known;
      status_type         status;
      logic [COUNT_W-1:0] edge_count;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [NODE_W-1:0] csr_wr_data;

   cer_req_if req_bus ();
   cer_rsp_if rsp_bus ();

   connected_edge_removal u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the graph, kept in step with every accepted request.
   logic [MAX_NODES_DEF-1:0] graph_rows [MAX_NODES_DEF];
   logic [COUNT_W-1:0]       graph_edges;
   logic [NODE_W-1:0]        graph_node_count;

   graph_result_type pending_results [$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count;
   int unsigned      send_idle_pct;
   int unsigned      rsp_idle_pct;

   // Directed table: range errors, present and absent edges, self loops,
   // a refused removal, node counts of 3, 1, 0 and 63 (which acts as 32).
   stim_row_type directed_rows [ROWS] = '{
      '{1'b0, 6'd0,  CMD_ADD,    6'd1,  6'd2,  1'b1, STATUS_DONE,       10'd1},
      '{1'b0, 6'd0,  CMD_ADD,    6'd2,  6'd1,  1'b1, STATUS_DONE,       10'd1},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd2,  6'd3,  1'b1, STATUS_NO_EDGE,    10'd1},
      '{1'b0, 6'd0,  CMD_ADD,    6'd0,  6'd5,  1'b1, STATUS_RANGE,      10'd1},
      '{1'b0, 6'd0,  CMD_ADD,    6'd1,  6'd33, 1'b1, STATUS_RANGE,      10'd1},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd63, 6'd63, 1'b1, STATUS_RANGE,      10'd1},
      '{1'b0, 6'd0,  CMD_ADD,    6'd32, 6'd32, 1'b1, STATUS_DONE,       10'd2},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd1,  6'd2,  1'b1, STATUS_DISCONNECT, 10'd2},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd32, 6'd32, 1'b0, STATUS_DONE,       10'd0},
      '{1'b1, 6'd3,  CMD_ADD,    6'd0,  6'd0,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_ADD,    6'd2,  6'd3,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_ADD,    6'd3,  6'd1,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd1,  6'd3,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd2,  6'd3,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_ADD,    6'd4,  6'd1,  1'b1, STATUS_RANGE,      10'd3},
      '{1'b1, 6'd1,  CMD_ADD,    6'd0,  6'd0,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd1,  6'd2,  1'b1, STATUS_RANGE,      10'd3},
      '{1'b0, 6'd0,  CMD_ADD,    6'd1,  6'd1,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd1,  6'd1,  1'b0, STATUS_DONE,       10'd0},
      '{1'b1, 6'd0,  CMD_ADD,    6'd0,  6'd0,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_ADD,    6'd1,  6'd1,  1'b1, STATUS_RANGE,      10'd3},
      '{1'b1, 6'd63, CMD_ADD,    6'd0,  6'd0,  1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_ADD,    6'd32, 6'd31, 1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_ADD,    6'd33, 6'd1,  1'b1, STATUS_RANGE,      10'd4},
      '{1'b0, 6'd0,  CMD_ADD,    6'd1,  6'd63, 1'b0, STATUS_DONE,       10'd0},
      '{1'b0, 6'd0,  CMD_REMOVE, 6'd31, 6'd32, 1'b0, STATUS_DONE,       10'd0}
   };

   // Random segments: node_count setting and number of requests for each.
   // Segments 0-2 idle the receiver, 3-5 the sender, 6-8 neither.
   int unsigned seg_nodes [SEGMENTS] = '{32, 6, 0, 63, 2, 12, 1, 32, 5};
   int unsigned seg_len   [SEGMENTS] = '{250, 150, 40, 250, 100, 150, 40, 350, 270};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the shadow graph and return the response it must give.
   function automatic graph_result_type apply_graph_request(input logic cmd,
                                                            input logic [NODE_W-1:0] from_node,
                                                            input logic [NODE_W-1:0] to_node);
      graph_result_type         res;
      int unsigned              n, a, b, i;
      logic [MAX_NODES_DEF-1:0] span, reached, grown;
      n = (graph_node_count > MAX_NODES_DEF) ? MAX_NODES_DEF : graph_node_count;
      span = MAX_NODES_DEF'((64'd1 << n) - 64'd1);
      res.status = STATUS_DONE;
      if (from_node == 0 || to_node == 0 || from_node > n || to_node > n) begin
         res.status = STATUS_RANGE;
      end else begin
         a = from_node - 1;
         b = to_node - 1;
         if (cmd == CMD_ADD) begin
            if (!graph_rows[a][b]) begin
               graph_rows[a][b] = 1'b1;
               graph_rows[b][a] = 1'b1;
               graph_edges++;
            end
         end else if (!graph_rows[a][b]) begin
            res.status = STATUS_NO_EDGE;
         end else begin
            graph_rows[a][b] = 1'b0;
            graph_rows[b][a] = 1'b0;
            // grow the reached set from node 1 until it stops changing;
            // nodes above the node count never join
            reached = '0;
            reached[0] = 1'b1;
            grown = '0;
            while (grown != reached) begin
               grown = reached;
               for (i = 0; i < n; i++)
                  if (grown[i]) reached |= graph_rows[i] & span;
            end
            if ($countones(reached & span) < n) begin
               graph_rows[a][b] = 1'b1;
               graph_rows[b][a] = 1'b1;
               res.status = STATUS_DISCONNECT;
            end else begin
               graph_edges--;
            end
         end
      end
      res.edge_count = graph_edges;
      return res;
   endfunction

   // Present one request, hold it until accepted, then record its expected response.
   task automatic issue_request(input logic cmd, input logic [NODE_W-1:0] from_node,
                                input logic [NODE_W-1:0] to_node, input bit known,
                                input status_type status, input logic [COUNT_W-1:0] edge_count);
      graph_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.from_node <= from_node;
      req_bus.to_node   <= to_node;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_graph_request(cmd, from_node, to_node);
      if (known) begin
         predicted.status     = status;
         predicted.edge_count = edge_count;
      end
      pending_results.push_back(predicted);
   endtask

   // Drop valid and hold off until every outstanding response has come back.
   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write node_count only once the block has gone idle.
   task automatic write_node_count(input logic [NODE_W-1:0] value);
      wait_for_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      graph_node_count = value;
   endtask

   // Receiver: drop ready at random at the current idle rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Compare every accepted response with the oldest expectation.
   always @(posedge clock) begin : check_responses
      graph_result_type oldest;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d edge_count %0d",
                        rsp_bus.status, rsp_bus.edge_count);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_bus.status !== oldest.status || rsp_bus.edge_count !== oldest.edge_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected status %0d edge_count %0d, ",
                            "got status %0d edge_count %0d"},
                           oldest.status, oldest.edge_count, rsp_bus.status, rsp_bus.edge_count);
            end
         end
      end
   end

   // Give up on a hung block.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL connected_edge_removal");
      $finish;
   end

   initial begin : stimulus
      int unsigned              seg, k, n, roll, a, b, tries;
      logic                     cmd;
      logic [NODE_W-1:0]        from_node, to_node;
      logic [MAX_NODES_DEF-1:0] span;

      // drive every input to a known value before the first edge
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_ADD;
      req_bus.from_node = '0;
      req_bus.to_node   = '0;
      send_idle_pct     = 6;
      rsp_idle_pct      = 53;
      graph_edges       = '0;
      graph_node_count  = NODE_COUNT_RESET;
      for (a = 0; a < MAX_NODES_DEF; a++) graph_rows[a] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_cfg)
            write_node_count(directed_rows[r].cfg_value);
         else
            issue_request(directed_rows[r].cmd, directed_rows[r].from_node,
                          directed_rows[r].to_node, directed_rows[r].known,
                          directed_rows[r].status, directed_rows[r].edge_count);
      end

      // random segments, each opened by a drain and a node_count write
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 3) begin
            send_idle_pct = 53;
            rsp_idle_pct  = 6;
         end else if (seg == 6) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         write_node_count(NODE_W'(seg_nodes[seg]));
         n = (seg_nodes[seg] > MAX_NODES_DEF) ? MAX_NODES_DEF : seg_nodes[seg];
         span = MAX_NODES_DEF'((64'd1 << n) - 64'd1);
         for (k = 0; k < seg_len[seg]; k++) begin
            roll      = $urandom_range(99);
            cmd       = 1'($urandom_range(1));
            // noise by default: any endpoint value the field can carry
            from_node = NODE_W'($urandom_range(63));
            to_node   = NODE_W'($urandom_range(63));
            if (roll >= 8 && n != 0) begin
               from_node = NODE_W'($urandom_range(n, 1));
               to_node   = NODE_W'($urandom_range(n, 1));
               if (cmd == CMD_REMOVE && roll < 80) begin
                  // aim most removals at a present edge so the walk runs
                  a = $urandom_range(n - 1);
                  for (tries = 0; tries < n && (graph_rows[a] & span) == 0; tries++)
                     a = (a + 1) % n;
                  if ((graph_rows[a] & span) != 0) begin
                     b = $urandom_range(n - 1);
                     while (!graph_rows[a][b]) b = (b + 1) % n;
                     from_node = NODE_W'(a + 1);
                     to_node   = NODE_W'(b + 1);
                  end
               end else if (cmd == CMD_ADD && roll < 50) begin
                  // chain neighbors so that large graphs become connected
                  to_node = (from_node == NODE_W'(n)) ? NODE_W'(1) : from_node + NODE_W'(1);
               end
            end
            issue_request(cmd, from_node, to_node, 1'b0, STATUS_DONE, '0);
         end
      end

      // drain, then keep the clock running to catch stray responses
      wait_for_responses();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS connected_edge_removal");
      else
         $display("FAIL connected_edge_removal");
      $finish;
   end

endmodule
